// ----- rtl/gcfp_pkg.sv -----
// package for the grid cell first-point filter
// holds payload structs, register indexes, sizes and the sequencer states; no dependencies
package gcfp_pkg;

	localparam int TableDepth = 1024;
	localparam int AddrW = $clog2(TableDepth);
	localparam int CountW = $clog2(TableDepth + 1);
	localparam int DivW = 32;
	localparam int StepW = $clog2(DivW + 1);

	localparam logic [0:0] RegCellSize = 1'b0;
	localparam logic [0:0] RegTargetHeight = 1'b1;
	localparam logic [30:0] CellSizeReset = 31'd3277;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_z;
		logic [31:0] attribute;
		logic end_of_cloud;
	} point_in_t;

	typedef struct packed {
		logic kept;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [31:0] out_attribute;
		logic overflow;
		logic [10:0] kept_total;
		logic cloud_done;
	} point_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX,
		ST_SCAN,
		ST_READ,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/grid_cell_first_point_filter.sv -----
// grid cell first-point filter top level
// depends on gcfp_pkg for payload structs, sizes and states
//
// Usage: one point enters on in_valid/in_stall and exactly one result leaves on
// out_valid/out_stall, in input order. The config channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) writes cell_size (index 0) and target_height (index 1);
// write only while idle.
// Per point, one shared restoring divider runs 32 steps for |x| / cell size,
// then 32 steps for |z| / cell size, each followed by a fix-up step for floor
// rounding. The cell key store (1024 x 64, one read port) is then scanned
// one entry at a time (read, then compare) over the occupied entries; the
// next point is taken in the cycle after the result transfer at the earliest.
// The table is a fill-count store, so reset needs no clearing pass.
// The result sits in an output register; while out_stall is high it holds and
// no new point is accepted. Reset empties the cell set and restores the
// registers to cell size 3277 and target height 0. A point with end_of_cloud
// set empties the set after its result is formed.
module grid_cell_first_point_filter (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input gcfp_pkg::point_in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output gcfp_pkg::point_out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [31:0] cfg_data
);

	gcfp_pkg::state_t state_q, state_d;
	gcfp_pkg::point_in_t pt_q;
	logic [30:0] cell_size_q;
	logic [31:0] target_height_q;
	logic [gcfp_pkg::CountW-1:0] count_q;
	logic [63:0] cell_keys [gcfp_pkg::TableDepth];
	logic [63:0] rd_q;
	logic [gcfp_pkg::CountW-1:0] idx_q;
	logic axis_q;
	logic [31:0] quo_q, rem_q, mag_q, den_q, qx_q, key_z;
	logic neg_q;
	logic [gcfp_pkg::StepW-1:0] step_q;
	logic [32:0] trial;
	logic [31:0] fq;
	logic last_step, hit, scan_end, accept;
	gcfp_pkg::point_out_t res_q;
	logic out_valid_q;

	assign in_stall = (state_q != gcfp_pkg::ST_IDLE) || out_valid_q;
	assign accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = res_q;

	// divider step and floor correction
	assign trial = {rem_q, mag_q[31]} - {1'b0, den_q};
	assign last_step = (step_q == gcfp_pkg::StepW'(gcfp_pkg::DivW - 1));
	assign fq = (neg_q && rem_q != 32'd0) ? ~quo_q : (neg_q ? (~quo_q + 32'd1) : quo_q);
	assign key_z = fq;
	assign hit = (rd_q == {qx_q, key_z});
	assign scan_end = (idx_q == count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gcfp_pkg::ST_IDLE: if (accept) state_d = gcfp_pkg::ST_DIV;
			gcfp_pkg::ST_DIV: if (last_step) state_d = gcfp_pkg::ST_FIX;
			gcfp_pkg::ST_FIX: state_d = axis_q ? gcfp_pkg::ST_SCAN : gcfp_pkg::ST_DIV;
			gcfp_pkg::ST_SCAN: state_d = scan_end ? gcfp_pkg::ST_DONE : gcfp_pkg::ST_READ;
			gcfp_pkg::ST_READ: state_d = hit ? gcfp_pkg::ST_DONE : gcfp_pkg::ST_SCAN;
			gcfp_pkg::ST_DONE: state_d = gcfp_pkg::ST_IDLE;
			default: state_d = gcfp_pkg::ST_IDLE;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcfp_pkg::ST_IDLE;
			cell_size_q <= gcfp_pkg::CellSizeReset;
			target_height_q <= 32'd0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gcfp_pkg::RegCellSize: cell_size_q <= cfg_data[30:0];
					gcfp_pkg::RegTargetHeight: target_height_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (state_q == gcfp_pkg::ST_DONE) begin
				out_valid_q <= 1'b1;
				if (pt_q.end_of_cloud) count_q <= '0;
				else if (res_q.kept) count_q <= count_q + 1'b1;
			end
		end
	end

	// datapath: divider, scan and result forming
	always_ff @(posedge clk) begin
		case (state_q)
			gcfp_pkg::ST_IDLE: begin
				if (accept) begin
					pt_q <= in_data;
					axis_q <= 1'b0;
					step_q <= '0;
					rem_q <= '0;
					neg_q <= in_data.pos_x[31];
					mag_q <= in_data.pos_x[31] ? -in_data.pos_x : in_data.pos_x;
					den_q <= (cell_size_q == 31'd0) ? 32'd1 : {1'b0, cell_size_q};
				end
			end
			gcfp_pkg::ST_DIV: begin
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], mag_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
				mag_q <= {mag_q[30:0], 1'b0};
				step_q <= step_q + 1'b1;
			end
			gcfp_pkg::ST_FIX: begin
				if (!axis_q) begin
					qx_q <= fq;
					axis_q <= 1'b1;
					step_q <= '0;
					rem_q <= '0;
					neg_q <= pt_q.pos_z[31];
					mag_q <= pt_q.pos_z[31] ? -pt_q.pos_z : pt_q.pos_z;
				end else begin
					qx_q <= qx_q;
					quo_q <= fq;
					rem_q <= '0;
					neg_q <= 1'b0;
					idx_q <= '0;
					res_q.kept <= 1'b0;
				end
			end
			gcfp_pkg::ST_SCAN: begin
				if (!scan_end) rd_q <= cell_keys[idx_q[gcfp_pkg::AddrW-1:0]];
				else if (count_q < gcfp_pkg::CountW'(gcfp_pkg::TableDepth)) begin
					cell_keys[count_q[gcfp_pkg::AddrW-1:0]] <= {qx_q, key_z};
					res_q.kept <= 1'b1;
				end
				res_q.overflow <= scan_end &&
					!(count_q < gcfp_pkg::CountW'(gcfp_pkg::TableDepth));
			end
			gcfp_pkg::ST_READ: begin
				idx_q <= idx_q + 1'b1;
				res_q.overflow <= 1'b0;
			end
			gcfp_pkg::ST_DONE: begin
				res_q.out_x <= res_q.kept ? pt_q.pos_x : 32'sd0;
				res_q.out_y <= res_q.kept ? $signed(target_height_q) : 32'sd0;
				res_q.out_z <= res_q.kept ? pt_q.pos_z : 32'sd0;
				res_q.out_attribute <= res_q.kept ? pt_q.attribute : 32'd0;
				res_q.kept_total <= 11'(count_q + (res_q.kept ? 1'b1 : 1'b0));
				res_q.cloud_done <= pt_q.end_of_cloud;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// no new point while a result waits
	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("point taken while result pending");
	// a result is never both kept and overflow
	a_kept_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.kept && out_data.overflow))
		else $error("kept and overflow together");
	// the occupied count never passes the table depth
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= gcfp_pkg::CountW'(gcfp_pkg::TableDepth)) else $error("count overrun");
`endif

endmodule
